// ===== rtl/amgs_pkg.sv =====
// Package for the adjacency matrix graph store.
// Holds payload structs, operation codes, result kinds and the control/status
// structs shared by the controller, the datapath and the top level.
package amgs_pkg;

    // Graph size and derived widths
    localparam int MAX_VERTICES = 64;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int GRP_W        = 8;
    localparam int GROUPS       = MAX_VERTICES / GRP_W;
    localparam int GRP_IDX_W    = $clog2(GROUPS);
    localparam int GRP_BIT_W    = $clog2(GRP_W);
    localparam int GRP_CNT_W    = $clog2(GRP_W + 1);

    // Configuration port
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;
    localparam int VCOUNT_W         = 7;
    localparam logic REG_IDX_VCOUNT = 1'b0;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    typedef logic [MAX_VERTICES-1:0] row_t;

    // Operation codes
    typedef enum logic [2:0] {
        FUNC_ADD    = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_IS     = 3'd2,
        FUNC_DEGREE = 3'd3,
        FUNC_NEIGH  = 3'd4
    } func_t;

    // Input transaction
    typedef struct packed {
        logic [2:0] func;
        logic [5:0] vertex_a;
        logic [5:0] vertex_b;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic       status;
        logic       edge_present;
        logic [6:0] degree;
        logic [5:0] neighbour;
        logic       neighbour_valid;
        logic       last;
    } out_item_t;

    // Which result the datapath assembles
    typedef enum logic [2:0] {
        RES_PLAIN,
        RES_RANGE,
        RES_EDGE,
        RES_DEGREE,
        RES_NEIGH
    } res_kind_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B,
        ST_CNT1,
        ST_CNT2,
        ST_EMIT,
        ST_NEIGH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_item;
        logic      rd_en;
        logic      wr_en;
        logic      sel_b;
        logic      load_work;
        logic      load_deg;
        logic      out_load;
        logic      nb_step;
        res_kind_t kind;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic  func_bad;
        logic  range_err;
        func_t func;
        logic  work_zero;
        logic  nb_single;
        logic  out_free;
    } status_t;

endpackage

// ===== rtl/amgs_ctrl.sv =====
// Controller state machine of the adjacency matrix graph store.
// Sequences row reads/writes, degree count and neighbour listing; uses amgs_pkg.
module amgs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  amgs_pkg::status_t st,
    output amgs_pkg::cmd_t    cmd
);
    import amgs_pkg::*;

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    // State and pending result kind
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= RES_PLAIN;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.kind      = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (st.func_bad) begin
                    kind_next  = RES_PLAIN;
                    state_next = ST_EMIT;
                end else if (st.range_err) begin
                    kind_next  = RES_RANGE;
                    state_next = ST_EMIT;
                end else begin
                    // fetch row a for every valid operation
                    cmd.rd_en = 1'b1;
                    unique case (st.func)
                        FUNC_ADD, FUNC_REMOVE: state_next = ST_WR_A;
                        FUNC_IS: begin
                            kind_next  = RES_EDGE;
                            state_next = ST_EMIT;
                        end
                        default: state_next = ST_CNT1;
                    endcase
                end
            end
            ST_WR_A: begin
                cmd.wr_en  = 1'b1;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.rd_en  = 1'b1;
                cmd.sel_b  = 1'b1;
                state_next = ST_WR_B;
            end
            ST_WR_B: begin
                cmd.wr_en  = 1'b1;
                cmd.sel_b  = 1'b1;
                kind_next  = RES_PLAIN;
                state_next = ST_EMIT;
            end
            ST_CNT1: begin
                cmd.load_work = 1'b1;
                state_next    = ST_CNT2;
            end
            ST_CNT2: begin
                cmd.load_deg = 1'b1;
                if (st.func == FUNC_DEGREE) begin
                    kind_next  = RES_DEGREE;
                    state_next = ST_EMIT;
                end else if (st.work_zero) begin
                    kind_next  = RES_PLAIN;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_NEIGH;
                end
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_NEIGH: begin
                cmd.kind = RES_NEIGH;
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.nb_step  = 1'b1;
                    if (st.nb_single) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/amgs_datapath.sv =====
// Datapath of the adjacency matrix graph store: item register, row memory with
// per-row valid bits, degree tree, neighbour scan and result register. Uses amgs_pkg.
module amgs_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  amgs_pkg::in_item_t              s_data,
    input  logic [amgs_pkg::VCOUNT_W-1:0]   active_count,
    input  amgs_pkg::cmd_t                  cmd,
    output amgs_pkg::status_t               st,
    output logic                            m_valid,
    input  logic                            m_ready,
    output amgs_pkg::out_item_t             m_data
);
    import amgs_pkg::*;

    // Popcount of one column group
    function automatic logic [GRP_CNT_W-1:0] grp_count(input logic [GRP_W-1:0] v);
        logic [GRP_CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < GRP_W; i++) begin
            c = c + GRP_CNT_W'(v[i]);
        end
        return c;
    endfunction

    // Lowest set bit: first nonzero group, then first bit inside it
    function automatic logic [VERT_W-1:0] lowest_set(input row_t v);
        logic [GRP_IDX_W-1:0] g;
        logic [GRP_BIT_W-1:0] b;
        logic [GRP_W-1:0]     grp;
        g = '0;
        b = '0;
        for (int i = GROUPS - 1; i >= 0; i--) begin
            if (v[i*GRP_W +: GRP_W] != '0) g = GRP_IDX_W'(i);
        end
        grp = v[g*GRP_W +: GRP_W];
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (grp[i]) b = GRP_BIT_W'(i);
        end
        return {g, b};
    endfunction

    in_item_t               item_reg;
    row_t                   mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    row_t                   rd_data_reg;
    logic                   rd_vld_reg;
    row_t                   row_rd;
    row_t                   col_mask;
    row_t                   masked_row;
    row_t                   bit_sel;
    row_t                   wr_row;
    logic [VERT_W-1:0]      mem_addr;
    logic [VERT_W-1:0]      bit_idx;
    logic                   is_add;
    row_t                   work_reg;
    logic [GRP_CNT_W-1:0]   grp_reg [GROUPS];
    logic [CNT_W-1:0]       deg_reg;
    logic [CNT_W-1:0]       deg_sum;
    out_item_t              out_reg;
    out_item_t              out_next;
    logic                   out_valid_reg;
    func_t                  func_code;

    // Input item register
    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
    end

    assign func_code = func_t'(item_reg.func);
    assign is_add    = (func_code == FUNC_ADD);

    // Address and bit selection: row a with column b, or row b with column a
    assign mem_addr = cmd.sel_b ? item_reg.vertex_b : item_reg.vertex_a;
    assign bit_idx  = cmd.sel_b ? item_reg.vertex_a : item_reg.vertex_b;
    assign bit_sel  = row_t'(1) << bit_idx;
    assign wr_row   = is_add ? (row_rd | bit_sel) : (row_rd & ~bit_sel);

    // Row memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) mem[mem_addr] <= wr_row;
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[mem_addr];
            rd_vld_reg  <= row_valid_reg[mem_addr];
        end
    end

    // Row valid bits: a row never written reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.wr_en) begin
            row_valid_reg[mem_addr] <= 1'b1;
        end
    end

    assign row_rd = rd_vld_reg ? rd_data_reg : '0;

    // Columns in use
    always_comb begin
        for (int c = 0; c < MAX_VERTICES; c++) begin
            col_mask[c] = (VCOUNT_W'(c) < active_count);
        end
    end
    assign masked_row = row_rd & col_mask;

    // Degree tree stage one: group counts; working row for the scan
    always_ff @(posedge aclk) begin
        if (cmd.load_work) begin
            work_reg <= masked_row;
            for (int g = 0; g < GROUPS; g++) begin
                grp_reg[g] <= grp_count(masked_row[g*GRP_W +: GRP_W]);
            end
        end else if (cmd.nb_step) begin
            work_reg <= work_reg & (work_reg - row_t'(1));
        end
    end

    // Degree tree stage two
    always_comb begin
        deg_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            deg_sum = deg_sum + CNT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_deg) deg_reg <= deg_sum;
    end

    // Result assembly
    always_comb begin
        out_next      = '0;
        out_next.last = 1'b1;
        case (cmd.kind)
            RES_RANGE:  out_next.status       = 1'b1;
            RES_EDGE:   out_next.edge_present = row_rd[item_reg.vertex_b];
            RES_DEGREE: out_next.degree       = deg_reg;
            RES_NEIGH: begin
                out_next.degree          = deg_reg;
                out_next.neighbour       = lowest_set(work_reg);
                out_next.neighbour_valid = 1'b1;
                out_next.last            = st.nb_single;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Status to the controller
    assign st.func_bad  = (item_reg.func > 3'(FUNC_NEIGH));
    assign st.range_err = ({1'b0, item_reg.vertex_a} >= active_count) ||
                          ((func_code == FUNC_ADD || func_code == FUNC_REMOVE ||
                            func_code == FUNC_IS) &&
                           ({1'b0, item_reg.vertex_b} >= active_count));
    assign st.func      = func_code;
    assign st.work_zero = (work_reg == '0);
    assign st.nb_single = ((work_reg & (work_reg - row_t'(1))) == '0);
    assign st.out_free  = !out_valid_reg || m_ready;

endmodule

// ===== rtl/adjacency_matrix_graph_store_top.sv =====
// Adjacency matrix graph store, top level: configuration register port and
// instances of amgs_ctrl and amgs_datapath. Uses amgs_pkg.
//
// Stores an undirected graph of up to 64 vertices as a symmetric 64 x 64 bit
// matrix, empty after reset (per-row valid bits, no clearing pass). One input
// transaction is taken at a time; the result register lets the next one be
// accepted while the last result still waits. Add/remove edge does a
// read-modify-write of two rows through the single-port row memory, is-edge
// reads one row, degree reads a row into a two-stage popcount tree, and
// neighbours yields its results from a lowest-set-bit scan, one result per
// cycle while the result channel takes them; out-of-range or unused codes
// answer without a row read. A stalled result stalls the controller.
// vertex_count lies at byte address 0; values above 64 act as 64.
module adjacency_matrix_graph_store_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  amgs_pkg::in_item_t             s_data,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output amgs_pkg::out_item_t            m_data,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [amgs_pkg::PADDR_W-1:0]   paddr,
    input  logic [amgs_pkg::PDATA_W-1:0]   pwdata,
    output logic [amgs_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import amgs_pkg::*;

    logic [VCOUNT_W-1:0] vertex_count_reg;
    logic [VCOUNT_W-1:0] active_count;
    logic                reg_hit;
    status_t             st;
    cmd_t                cmd;

    // Register decode: paddr[2] selects the register index
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_IDX_VCOUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VCOUNT_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            vertex_count_reg <= pwdata[VCOUNT_W-1:0];
        end
    end

    assign prdata = reg_hit ? PDATA_W'(vertex_count_reg) : '0;

    // Saturate to the matrix size
    assign active_count = (vertex_count_reg > VCOUNT_W'(MAX_VERTICES)) ?
                          VCOUNT_W'(MAX_VERTICES) : vertex_count_reg;

    amgs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    amgs_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data       (s_data),
        .active_count (active_count),
        .cmd          (cmd),
        .st           (st),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
